>>> hdl/isl_pkg.sv
`default_nettype none
package isl_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;

	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 4;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int ERROR_W  = 2;

	localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_GET    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SWAP   = 3'd4;

	localparam logic [ERROR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERROR_W-1:0] ERR_RANGE = 2'd1;
	localparam logic [ERROR_W-1:0] ERR_FULL  = 2'd2;

endpackage
`default_nettype wire

>>> hdl/isl_req_if.sv
`default_nettype none
interface isl_req_if;
	import isl_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [INDEX_W-1:0]  index;
	logic [INDEX_W-1:0]  second_index;
	logic [VALUE_W-1:0]  value;

	modport source (output valid, output opcode, output index, output second_index,
		output value, input ready);
	modport sink (input valid, input opcode, input index, input second_index,
		input value, output ready);
endinterface
`default_nettype wire

>>> hdl/isl_res_if.sv
`default_nettype none
interface isl_res_if;
	import isl_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0] count;
	logic [ERROR_W-1:0] error_code;
	logic               empty_res;

	modport source (output valid, output read_value, output count, output error_code,
		output empty_res, input ready);
	modport sink (input valid, input read_value, input count, input error_code,
		input empty_res, output ready);
endinterface
`default_nettype wire

>>> hdl/isl_mem.sv
`default_nettype none
module isl_mem #(
	parameter int DEPTH      = isl_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = isl_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WORD_WIDTH-1:0]    wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WORD_WIDTH-1:0]    rd_data
);
	import isl_pkg::*;

	logic [WORD_WIDTH-1:0] mem_q [DEPTH];
	logic [WORD_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

>>> hdl/isl_ctrl.sv
`default_nettype none
module isl_ctrl #(
	parameter int DEPTH      = isl_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = isl_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	isl_req_if.sink                       req,
	isl_res_if.source                     res,
	output logic                          mem_we,
	output logic      [$clog2(DEPTH)-1:0] mem_waddr,
	output logic      [WORD_WIDTH-1:0]    mem_wdata,
	output logic                          mem_re,
	output logic      [$clog2(DEPTH)-1:0] mem_raddr,
	input  wire logic [WORD_WIDTH-1:0]    mem_rd_data
);
	import isl_pkg::*;

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_GRD   = 4'd1;
	localparam logic [3:0] ST_GCAP  = 4'd2;
	localparam logic [3:0] ST_SHIFT = 4'd3;
	localparam logic [3:0] ST_PUT   = 4'd4;
	localparam logic [3:0] ST_SWA   = 4'd5;
	localparam logic [3:0] ST_SWB   = 4'd6;
	localparam logic [3:0] ST_SWC   = 4'd7;
	localparam logic [3:0] ST_SWD   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]            state_q;
	logic [CW-1:0]         count_q;
	logic                  more_q;
	logic                  pend_s1;
	logic                  out_valid_q;

	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         idx2_q;
	logic [WORD_WIDTH-1:0] val_q;
	logic                  ins_q;
	logic [ERROR_W-1:0]    err_q;
	logic [WORD_WIDTH-1:0] rd_q;
	logic [IW-1:0]         ptr_q;
	logic [IW-1:0]         end_q;
	logic                  up_q;
	logic [IW-1:0]         wa_s1;
	logic [WORD_WIDTH-1:0] tmp_q;

	logic [VALUE_W-1:0]    out_value_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic [ERROR_W-1:0]    out_err_q;
	logic                  out_empty_q;

	logic                  accept;
	logic                  out_load;
	logic [CMPW-1:0]       idx_c;
	logic [CMPW-1:0]       idx2_c;
	logic [CMPW-1:0]       cnt_c;
	logic                  idx_ok;
	logic                  idx2_ok;
	logic                  full;
	logic [IW-1:0]         idx_n;
	logic [CW-1:0]         cnt_m1;
	logic [IW-1:0]         last_idx;
	logic [ERROR_W-1:0]    err_c;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || res.ready);

	assign idx_c    = CMPW'(req.index);
	assign idx2_c   = CMPW'(req.second_index);
	assign cnt_c    = CMPW'(count_q);
	assign idx_ok   = idx_c < cnt_c;
	assign idx2_ok  = idx2_c < cnt_c;
	assign full     = (count_q == CW'(DEPTH));
	assign idx_n    = IW'(req.index);
	assign cnt_m1   = count_q - CW'(1);
	assign last_idx = IW'(cnt_m1);

	always_comb begin
		err_c = ERR_OK;
		case (req.opcode)
			OP_APPEND: begin
				if (full) err_c = ERR_FULL;
			end
			OP_INSERT: begin
				if (!idx_ok) err_c = ERR_RANGE;
				else if (full) err_c = ERR_FULL;
			end
			OP_GET, OP_REMOVE: begin
				if (!idx_ok) err_c = ERR_RANGE;
			end
			OP_SWAP: begin
				if (!(idx_ok && idx2_ok)) err_c = ERR_RANGE;
			end
			default: begin
				err_c = ERR_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			more_q      <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						state_q <= ST_OUT;
						if (err_c == ERR_OK) begin
							case (req.opcode)
								OP_APPEND: begin
									count_q <= count_q + CW'(1);
									state_q <= ST_PUT;
								end
								OP_INSERT: begin
									count_q <= count_q + CW'(1);
									more_q  <= 1'b1;
									state_q <= ST_SHIFT;
								end
								OP_GET: begin
									state_q <= ST_GRD;
								end
								OP_REMOVE: begin
									count_q <= cnt_m1;
									if (idx_n != last_idx) begin
										more_q  <= 1'b1;
										state_q <= ST_SHIFT;
									end
								end
								OP_SWAP: begin
									state_q <= ST_SWA;
								end
								default: begin
									state_q <= ST_OUT;
								end
							endcase
						end
					end
				end
				ST_GRD:  state_q <= ST_GCAP;
				ST_GCAP: state_q <= ST_OUT;
				ST_SHIFT: begin
					pend_s1 <= more_q;
					if (more_q) begin
						if (ptr_q == end_q) more_q <= 1'b0;
					end else begin
						state_q <= ins_q ? ST_PUT : ST_OUT;
					end
				end
				ST_PUT: state_q <= ST_OUT;
				ST_SWA: state_q <= ST_SWB;
				ST_SWB: state_q <= ST_SWC;
				ST_SWC: state_q <= ST_SWD;
				ST_SWD: state_q <= ST_OUT;
				ST_OUT: begin
					pend_s1 <= 1'b0;
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= (req.opcode == OP_APPEND) ? IW'(count_q) : idx_n;
			idx2_q <= IW'(req.second_index);
			val_q  <= WORD_WIDTH'(req.value);
			err_q  <= err_c;
			rd_q   <= '0;
			ins_q  <= (req.opcode == OP_INSERT);
			if (req.opcode == OP_INSERT) begin
				ptr_q <= last_idx;
				end_q <= idx_n;
				up_q  <= 1'b0;
			end else begin
				ptr_q <= idx_n + IW'(1);
				end_q <= last_idx;
				up_q  <= 1'b1;
			end
		end
		if (state_q == ST_SHIFT && more_q) begin
			wa_s1 <= up_q ? ptr_q - IW'(1) : ptr_q + IW'(1);
			ptr_q <= up_q ? ptr_q + IW'(1) : ptr_q - IW'(1);
		end
		if (state_q == ST_SWB) begin
			tmp_q <= mem_rd_data;
		end
		if (state_q == ST_GCAP) begin
			rd_q <= mem_rd_data;
		end
		if (out_load) begin
			out_value_q <= VALUE_W'(rd_q);
			out_count_q <= COUNT_W'(count_q);
			out_err_q   <= err_q;
			out_empty_q <= (count_q == '0);
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		case (state_q)
			ST_GRD: begin
				mem_re = 1'b1;
			end
			ST_SHIFT: begin
				mem_we    = pend_s1;
				mem_waddr = wa_s1;
				mem_wdata = mem_rd_data;
				mem_re    = more_q;
				mem_raddr = ptr_q;
			end
			ST_PUT: begin
				mem_we = 1'b1;
			end
			ST_SWA: begin
				mem_re = 1'b1;
			end
			ST_SWB: begin
				mem_re    = 1'b1;
				mem_raddr = idx2_q;
			end
			ST_SWC: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rd_data;
			end
			ST_SWD: begin
				mem_we    = 1'b1;
				mem_waddr = idx2_q;
				mem_wdata = tmp_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign res.valid      = out_valid_q;
	assign res.read_value = out_value_q;
	assign res.count      = out_count_q;
	assign res.error_code = out_err_q;
	assign res.empty_res  = out_empty_q;
endmodule
`default_nettype wire

>>> hdl/indexed_shift_list.sv
// one transaction at a time; the entry move loop through the single ram port pair sets the rate
// errors, unknown opcodes and removing the last entry go straight to the result state;
// append writes in ST_PUT, get reads in ST_GRD and captures in ST_GCAP, swap reads both
// entries, then writes them crosswise; insert shifts up then writes, remove shifts down
// the next request is taken in the cycle after its result is registered
// reset clears the count, the sequencer and the output valid; ram contents are not cleared
`default_nettype none
module indexed_shift_list #(
	parameter int DEPTH      = isl_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = isl_pkg::WORD_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	isl_req_if.sink   req,
	isl_res_if.source res
);
	import isl_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [WORD_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [IW-1:0]         mem_raddr;
	logic [WORD_WIDTH-1:0] mem_rd_data;

	isl_ctrl #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rd_data (mem_rd_data)
	);

	isl_mem #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rd_data (mem_rd_data)
	);
endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
	import isl_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_RESERVED = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_LAST     = 3'd7;
	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 95;
	localparam int LONG_HOLD = 90;

	localparam int MODE_GROW = 0;
	localparam int MODE_MIXED = 1;
	localparam int MODE_SHRINK = 2;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] count;
		logic [ERROR_W-1:0] error_code;
		logic               empty_res;
	} list_result_t;

	class list_scoreboard;
		logic [VALUE_W-1:0] entries[LIST_DEPTH];
		int unsigned live;
		int unsigned peak;
		list_result_t pending_q[$];
		int mismatches;
		int op_taken[8];
		int err_seen[4];

		function void note_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
			logic [INDEX_W-1:0] idx2, logic [VALUE_W-1:0] val);
			list_result_t r;
			logic [VALUE_W-1:0] held;
			r = '0;
			r.error_code = ERR_OK;
			case (op)
				OP_APPEND: begin
					if (live >= LIST_DEPTH) begin
						r.error_code = ERR_FULL;
					end else begin
						entries[live] = val;
						live++;
					end
				end
				OP_INSERT: begin
					if (idx >= live) begin
						r.error_code = ERR_RANGE;
					end else if (live >= LIST_DEPTH) begin
						r.error_code = ERR_FULL;
					end else begin
						for (int i = live; i > idx; i--)
							entries[i] = entries[i - 1];
						entries[idx] = val;
						live++;
					end
				end
				OP_GET: begin
					if (idx >= live)
						r.error_code = ERR_RANGE;
					else
						r.read_value = entries[idx];
				end
				OP_REMOVE: begin
					if (idx >= live) begin
						r.error_code = ERR_RANGE;
					end else begin
						for (int i = idx; i + 1 < live; i++)
							entries[i] = entries[i + 1];
						live--;
					end
				end
				OP_SWAP: begin
					if (idx >= live || idx2 >= live) begin
						r.error_code = ERR_RANGE;
					end else begin
						held = entries[idx];
						entries[idx] = entries[idx2];
						entries[idx2] = held;
					end
				end
				default: ;
			endcase
			r.count = live[COUNT_W-1:0];
			r.empty_res = (live == 0);
			if (live > peak)
				peak = live;
			op_taken[op]++;
			err_seen[r.error_code]++;
			pending_q.push_back(r);
		endfunction

		task report(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
			mismatches++;
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		endtask

		task check_result(list_result_t got);
			list_result_t want;
			if (pending_q.size() == 0) begin
				report("result with no transaction outstanding, count", got.count, 0);
			end else begin
				want = pending_q.pop_front();
				if (got.read_value !== want.read_value)
					report("read_value", got.read_value, want.read_value);
				if (got.count !== want.count)
					report("count", got.count, want.count);
				if (got.error_code !== want.error_code)
					report("error_code", got.error_code, want.error_code);
				if (got.empty_res !== want.empty_res)
					report("empty_res", got.empty_res, want.empty_res);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit sender_fast;
	bit receiver_fast;
	bit long_hold_req;

	list_scoreboard sb = new();

	isl_req_if req_bus();
	isl_res_if res_bus();

	indexed_shift_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.res(res_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				sb.note_request(req_bus.opcode, req_bus.index, req_bus.second_index,
					req_bus.value);
			if (res_bus.valid && res_bus.ready)
				sb.check_result({res_bus.read_value, res_bus.count, res_bus.error_code,
					res_bus.empty_res});
		end
	end

	// result side back-pressure
	initial begin
		int hold;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				hold = receiver_fast ? 0 : $urandom_range(0, 11);
			end
			repeat (hold) begin
				@(negedge clk);
				res_bus.ready <= 1'b0;
			end
			@(negedge clk);
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
		end
	end

	task automatic send_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
		logic [INDEX_W-1:0] idx2, logic [VALUE_W-1:0] val);
		int gap;
		gap = sender_fast ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.opcode <= op;
		req_bus.index <= idx;
		req_bus.second_index <= idx2;
		req_bus.value <= val;
		do @(posedge clk); while (!req_bus.ready);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		req_bus.valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [INDEX_W-1:0] pick_index();
		if (sb.live == 0 || $urandom_range(0, 4) == 0)
			return INDEX_W'($urandom_range(0, 15));
		return INDEX_W'($urandom_range(0, sb.live - 1));
	endfunction

	task automatic send_random(int mode);
		int pick;
		int app_w;
		int ins_w;
		int rem_w;
		logic [OPCODE_W-1:0] op;
		case (mode)
			MODE_GROW:   begin app_w = 32; ins_w = 26; rem_w = 12; end
			MODE_SHRINK: begin app_w = 10; ins_w = 10; rem_w = 42; end
			default:     begin app_w = 20; ins_w = 20; rem_w = 22; end
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 2)
			op = OPCODE_W'($urandom_range(OP_RESERVED, OP_LAST));
		else if (pick < 2 + app_w)
			op = OP_APPEND;
		else if (pick < 2 + app_w + ins_w)
			op = OP_INSERT;
		else if (pick < 2 + app_w + ins_w + rem_w)
			op = OP_REMOVE;
		else if (pick < 2 + app_w + ins_w + rem_w + (98 - app_w - ins_w - rem_w) / 2)
			op = OP_GET;
		else
			op = OP_SWAP;
		send_request(op, pick_index(), pick_index(), $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.opcode = OP_APPEND;
		req_bus.index = '0;
		req_bus.second_index = '0;
		req_bus.value = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list
		send_request(OP_GET, 0, 0, 0);
		send_request(OP_REMOVE, 0, 0, 0);
		send_request(OP_INSERT, 0, 0, $urandom);
		send_request(OP_SWAP, 0, 0, 0);
		send_request(OP_RESERVED, 15, 15, 32'hFFFF_FFFF);
		send_request(OP_APPEND, 0, 0, 32'h0000_0000);
		send_request(OP_APPEND, 0, 0, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 0, 15, 32'hA5A5_5A5A);
		send_request(OP_SWAP, 0, 2, 0);
		send_request(OP_SWAP, 1, 1, 0);
		send_request(OP_GET, 2, 0, 0);
		send_request(OP_REMOVE, 2, 0, 0);
		// fill up
		repeat (LIST_DEPTH - 2)
			send_request(OP_APPEND, 0, 0, $urandom);
		send_request(OP_APPEND, 0, 0, $urandom);
		send_request(OP_INSERT, 15, 0, $urandom);
		send_request(OP_GET, 15, 0, 0);
		send_request(OP_SWAP, 0, 15, 0);
		send_request(OP_REMOVE, 0, 0, 0);
		send_request(OP_GET, 15, 0, 0);
		send_request(OP_SWAP, 3, 15, 0);
		send_request(OP_INSERT, 13, 0, $urandom);
		send_request(OP_REMOVE, 15, 0, 0);
		wait_all_results();

		for (int phase = 0; phase < PHASES; phase++) begin
			sender_fast = (phase % 4 == 1);
			receiver_fast = (phase % 4 == 2);
			if (phase == 1 || phase == 9)
				long_hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				send_random(phase % 3);
			wait_all_results();
		end

		repeat (40) @(negedge clk);
		if (sb.pending_q.size() != 0)
			sb.report("transactions never answered", sb.pending_q.size(), 0);
		$display("covered: append %0d insert %0d get %0d remove %0d swap %0d unused ops %0d",
			sb.op_taken[OP_APPEND], sb.op_taken[OP_INSERT], sb.op_taken[OP_GET],
			sb.op_taken[OP_REMOVE], sb.op_taken[OP_SWAP],
			sb.op_taken[5] + sb.op_taken[6] + sb.op_taken[7]);
		$display("range errors %0d, full errors %0d, peak fill %0d of %0d, mismatches %0d",
			sb.err_seen[ERR_RANGE], sb.err_seen[ERR_FULL], sb.peak, LIST_DEPTH,
			sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
